/* rtl/int8_requantize_activation_assert.svh */
// Assertion macros shared by the modules of the requantiser.
`ifndef INT8_REQUANTIZE_ACTIVATION_ASSERT_SVH
`define INT8_REQUANTIZE_ACTIVATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IRQA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irqa: assertion failed");
`define IRQA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irqa: assertion failed");
`else
`define IRQA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define IRQA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/irqa_pkg.sv */
`default_nettype none
package irqa_pkg;

  localparam int CHANNELS    = 256;
  localparam int MULT_BITS   = 32;
  localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int WIDE_W      = 89;
  localparam int SHIFT_W     = 7;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_MULT   = 2'd1;
  localparam logic [1:0] KIND_BIAS   = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RELU  = 2'd1;
  localparam logic [1:0] ACT_LEAKY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_SLOPE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_PER_CHANNEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_PER_CHANNEL  = 3'd5;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [7:0]  channel;
    logic signed [31:0] accumulator;
    logic signed [47:0] table_word;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] quantized;
    logic        [7:0] out_channel;
  } result_t;

  typedef struct packed {
    logic [1:0]  act_mode;
    logic [23:0] leak_slope;
    logic [5:0]  result_shift;
    logic        bias_enable;
    logic        scale_per_channel;
    logic        bias_per_channel;
  } cfg_t;

  typedef struct packed {
    logic        [7:0]           channel;
    logic signed [31:0]          accumulator;
    logic signed [MULT_BITS-1:0] mult;
    logic signed [47:0]          bias;
  } job_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } queue_status_t;

endpackage
`default_nettype wire

/* rtl/irqa_ram.sv */
`default_nettype none
module irqa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/irqa_queue.sv */
`default_nettype none
`include "int8_requantize_activation_assert.svh"
module irqa_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire irqa_pkg::job_t         push_job,
  output irqa_pkg::queue_status_t     status,
  input  wire logic                   pop,
  output logic                        head_valid,
  output irqa_pkg::job_t              head_job
);

  irqa_pkg::job_t                   entries [irqa_pkg::QUEUE_DEPTH];
  logic [irqa_pkg::QPTR_W-1:0]      wr_ptr;
  logic [irqa_pkg::QPTR_W-1:0]      rd_ptr;
  logic [irqa_pkg::QLVL_W-1:0]      level;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + irqa_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + irqa_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + irqa_pkg::QLVL_W'(1);
        2'b01:   level <= level - irqa_pkg::QLVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  always_comb begin
    head_valid         = (level != '0);
    head_job           = entries[rd_ptr];
    status.full        = (level == irqa_pkg::QLVL_W'(irqa_pkg::QUEUE_DEPTH));
    status.almost_full = (level >= irqa_pkg::QLVL_W'(irqa_pkg::QUEUE_DEPTH - 1));
  end

  `IRQA_ASSERT_IMPLY(a_no_overflow, clk, rst, push,
                     level < irqa_pkg::QLVL_W'(irqa_pkg::QUEUE_DEPTH))
  `IRQA_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, level != '0)

endmodule
`default_nettype wire

/* rtl/irqa_front.sv */
`default_nettype none
module irqa_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire irqa_pkg::cfg_t          cfg,
  input  wire logic                    sample_valid,
  output logic                         sample_ready,
  input  wire irqa_pkg::sample_t       sample,
  input  wire irqa_pkg::queue_status_t status,
  output logic                         push,
  output irqa_pkg::job_t               push_job
);

  logic                           accept;
  logic                           in_range;
  logic                           mult_we;
  logic                           bias_we;
  logic                           is_sample;
  logic [irqa_pkg::IDX_W-1:0]     wr_addr;
  logic [irqa_pkg::IDX_W-1:0]     mult_raddr;
  logic [irqa_pkg::IDX_W-1:0]     bias_raddr;
  logic [irqa_pkg::MULT_BITS-1:0] mult_rdata;
  logic [47:0]                    bias_rdata;

  logic                           f1_valid;
  logic [7:0]                     f1_channel;
  logic signed [31:0]             f1_acc;
  logic                           f1_mult_ok;
  logic                           f1_bias_ok;

  always_comb begin
    sample_ready = !status.full && !(status.almost_full && f1_valid);
    accept       = sample_valid && sample_ready;
    in_range     = (32'(sample.channel) < 32'(irqa_pkg::CHANNELS));
    wr_addr      = irqa_pkg::IDX_W'(sample.channel);
    is_sample    = accept && (sample.kind == irqa_pkg::KIND_SAMPLE);
    mult_we      = accept && (sample.kind == irqa_pkg::KIND_MULT) && in_range;
    bias_we      = accept && (sample.kind == irqa_pkg::KIND_BIAS) && in_range;
    mult_raddr   = cfg.scale_per_channel ? wr_addr : '0;
    bias_raddr   = cfg.bias_per_channel ? wr_addr : '0;
  end

  irqa_ram #(
    .WIDTH (irqa_pkg::MULT_BITS),
    .DEPTH (irqa_pkg::CHANNELS)
  ) u_mult_ram (
    .clk   (clk),
    .we    (mult_we),
    .waddr (wr_addr),
    .wdata (sample.table_word[irqa_pkg::MULT_BITS-1:0]),
    .re    (is_sample),
    .raddr (mult_raddr),
    .rdata (mult_rdata)
  );

  irqa_ram #(
    .WIDTH (48),
    .DEPTH (irqa_pkg::CHANNELS)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (wr_addr),
    .wdata (sample.table_word),
    .re    (is_sample),
    .raddr (bias_raddr),
    .rdata (bias_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= is_sample;
    end
    if (is_sample) begin
      f1_channel <= sample.channel;
      f1_acc     <= sample.accumulator;
      f1_mult_ok <= !cfg.scale_per_channel || in_range;
      f1_bias_ok <= cfg.bias_enable && (!cfg.bias_per_channel || in_range);
    end
  end

  always_comb begin
    push                 = f1_valid;
    push_job.channel     = f1_channel;
    push_job.accumulator = f1_acc;
    push_job.mult        = f1_mult_ok ? mult_rdata : '0;
    push_job.bias        = f1_bias_ok ? bias_rdata : '0;
  end

endmodule
`default_nettype wire

/* rtl/irqa_back.sv */
`default_nettype none
`include "int8_requantize_activation_assert.svh"
module irqa_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire irqa_pkg::cfg_t   cfg,
  input  wire logic             job_valid,
  input  wire irqa_pkg::job_t   job,
  output logic                  take,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output irqa_pkg::result_t     result
);

  localparam int W = irqa_pkg::WIDE_W;

  logic adv;
  logic v1, v2, v3, v4, v5;

  logic [7:0] ch1, ch2, ch3, ch4, ch5;

  logic signed [63:0] prod1;
  logic signed [47:0] bias1;
  logic signed [63:0] prod_next;

  logic signed [63:0] val2;
  logic signed [63:0] val_next;

  logic signed [63:0] val3;
  logic        [55:0] plo3;
  logic signed [56:0] phi3;
  logic        [55:0] plo_next;
  logic signed [56:0] phi_next;

  logic signed [W-1:0]                x4;
  logic        [irqa_pkg::SHIFT_W-1:0] s4;
  logic signed [W-1:0]                x_next;
  logic        [irqa_pkg::SHIFT_W-1:0] s_next;
  logic                               leak;
  logic                               clamp;

  logic signed [W-1:0]                y5;
  logic        [irqa_pkg::SHIFT_W-1:0] s5;
  logic signed [W-1:0]                y_next;
  logic        [W-1:0]                half;

  logic signed [W-1:0] shifted;
  logic signed [7:0]   q_next;

  always_comb begin
    adv  = !result_valid || result_ready;
    take = adv && job_valid;

    prod_next = 64'(job.accumulator) * 64'(job.mult);
    val_next  = prod1 + 64'(bias1);
    plo_next  = 56'(val2[31:0]) * 56'(cfg.leak_slope);
    phi_next  = 57'($signed(val2[63:32])) * 57'($signed({1'b0, cfg.leak_slope}));

    leak  = val3[63] && (cfg.act_mode == irqa_pkg::ACT_LEAKY);
    clamp = val3[63] && (cfg.act_mode == irqa_pkg::ACT_RELU);
    if (leak) begin
      x_next = (W'(phi3) <<< 32) + W'(plo3);
    end else if (clamp) begin
      x_next = '0;
    end else begin
      x_next = W'(val3);
    end
    s_next = irqa_pkg::SHIFT_W'(cfg.result_shift) + (leak ? 7'd16 : 7'd0);

    half   = (s4 == '0) ? '0 : (W'(1) << (s4 - 7'd1));
    y_next = x4 + half;

    shifted = y5 >>> s5;
    if (shifted > W'(127)) begin
      q_next = 8'sd127;
    end else if (shifted < -W'(127)) begin
      q_next = -8'sd127;
    end else begin
      q_next = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= job_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= v4;
      result_valid <= v5;
    end
    if (adv) begin
      ch1                <= job.channel;
      prod1              <= prod_next;
      bias1              <= job.bias;
      ch2                <= ch1;
      val2               <= val_next;
      ch3                <= ch2;
      val3               <= val2;
      plo3               <= plo_next;
      phi3               <= phi_next;
      ch4                <= ch3;
      x4                 <= x_next;
      s4                 <= s_next;
      ch5                <= ch4;
      y5                 <= y_next;
      s5                 <= s4;
      result.quantized   <= q_next;
      result.out_channel <= ch5;
    end
  end

  `IRQA_ASSERT_IMPLY(a_relu_nonneg, clk, rst,
                     v5 && (cfg.act_mode == irqa_pkg::ACT_RELU), !y5[W-1])
  `IRQA_ASSERT_IMPLY(a_sat_range, clk, rst, result_valid,
                     result.quantized != 8'sh80)
  `IRQA_ASSERT_NEXT(a_last_stage_moves, clk, rst, adv && v5, result_valid)

endmodule
`default_nettype wire

/* rtl/int8_requantize_activation.sv */
// An accepted sample beat passes the front register, the job queue and back stages v1 to v5
// before its result is registered. Throughput: one beat per cycle while result_ready is high
// and the queue has room; each table has a single read port, and the back end is the
// six-stage multiply, bias, leak, round and saturate pipeline. Table-write beats produce no result beat.
// Reset (synchronous, active high) clears the valid flags, the configuration and the queue; the
// multiplier and bias tables are undefined until written.
`default_nettype none
module int8_requantize_activation (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output logic                                    sample_ready,
  input  wire irqa_pkg::sample_t                  sample,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output irqa_pkg::result_t                       result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [irqa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [irqa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  irqa_pkg::cfg_t          cfg;
  irqa_pkg::queue_status_t status;
  irqa_pkg::job_t          push_job;
  irqa_pkg::job_t          head_job;
  logic                    push;
  logic                    head_valid;
  logic                    take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        irqa_pkg::CFG_ACT_MODE:          cfg.act_mode          <= cfg_data[1:0];
        irqa_pkg::CFG_LEAK_SLOPE:        cfg.leak_slope        <= cfg_data;
        irqa_pkg::CFG_RESULT_SHIFT:      cfg.result_shift      <= cfg_data[5:0];
        irqa_pkg::CFG_BIAS_ENABLE:       cfg.bias_enable       <= cfg_data[0];
        irqa_pkg::CFG_SCALE_PER_CHANNEL: cfg.scale_per_channel <= cfg_data[0];
        irqa_pkg::CFG_BIAS_PER_CHANNEL:  cfg.bias_per_channel  <= cfg_data[0];
        default:                         cfg                   <= cfg;
      endcase
    end
  end

  irqa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .status       (status),
    .push         (push),
    .push_job     (push_job)
  );

  irqa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .status     (status),
    .pop        (take),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  irqa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (head_valid),
    .job          (head_job),
    .take         (take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
